/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication
`define CHK_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* rtl/ffra_pkg.sv */
package ffra_pkg;

	localparam int IDX_W = 16;
	localparam int ST_W  = 3;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK         = 3'd0;
	localparam logic [ST_W-1:0] ST_CAPACITY   = 3'd1;
	localparam logic [ST_W-1:0] ST_UNKNOWN    = 3'd2;
	localparam logic [ST_W-1:0] ST_LIST_FULL  = 3'd3;
	localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd4;

	// Request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// One free slot: start index and capacity
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] cap;
	} slot_t;

	// One allocation record
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] size;
	} tab_t;

	localparam int SLOT_W = $bits(slot_t);
	localparam int TAB_W  = $bits(tab_t);

endpackage

/* rtl/ffra_ram.sv */
module ffra_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/ffra_ctrl.sv */
module ffra_ctrl
	import ffra_pkg::*;
#(
	parameter int FREE_SLOT_DEPTH   = 32,
	parameter int ALLOC_TABLE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  logic [IDX_W-1:0] count,
	input  logic [IDX_W-1:0] handle,
	input  logic [IDX_W-1:0] max_index,
	output logic             busy,
	output logic             done,
	output logic [IDX_W-1:0] start_index,
	output logic [ST_W-1:0]  status
);

	localparam int FAW = $clog2(FREE_SLOT_DEPTH);
	localparam int FCW = $clog2(FREE_SLOT_DEPTH + 1);
	localparam int TAW = $clog2(ALLOC_TABLE_DEPTH);
	localparam int TCW = $clog2(ALLOC_TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_ATAB, S_ASLOT, S_ABUMP, S_SHDN,
		S_FTAB, S_FPOS, S_FDEC, S_FLM, S_SHUP, S_FINS
	} state_t;

	state_t           state_q;
	logic [TCW-1:0]   clr_q;
	logic [FCW-1:0]   fcnt_q;
	logic [IDX_W-1:0] bump_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] handle_q;
	logic [IDX_W-1:0] cap_q;
	logic [IDX_W-1:0] newcap_q;
	logic [FCW-1:0]   rp_q;
	logic [TCW-1:0]   tp_q;
	logic             pend_s1;
	logic [FCW-1:0]   spa_s1;
	logic [TAW-1:0]   tpa_s1;
	logic [TAW-1:0]   t_q;
	logic [FCW-1:0]   pos_q;
	logic             has_right_q;
	slot_t            left_q;
	slot_t            right_q;
	logic             s_we_q;
	logic [FAW-1:0]   s_wa_q;
	slot_t            s_wd_q;
	logic             t_we_q;
	logic [TAW-1:0]   t_wa_q;
	tab_t             t_wd_q;
	logic             done_q;
	logic [IDX_W-1:0] sidx_q;
	logic [ST_W-1:0]  status_q;

	slot_t            s_rd;
	tab_t             t_rd;
	logic [FAW-1:0]   s_ra;
	logic [FCW-1:0]   rp_dn;

	logic [IDX_W:0]   l_end, r_need, lm_end, bump_end;
	logic [IDX_W-1:0] shr_idx, shr_cap, newcap, rmcap, lrcap;
	logic             left_ok, right_ok;

	// Slot and table stores
	ffra_ram #(.W(SLOT_W), .DEPTH(FREE_SLOT_DEPTH)) u_slots (
		.clk   (clk),
		.we    (s_we_q),
		.waddr (s_wa_q),
		.wdata (s_wd_q),
		.raddr (s_ra),
		.rdata (s_rd)
	);

	ffra_ram #(.W(TAB_W), .DEPTH(ALLOC_TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (t_we_q),
		.waddr (t_wa_q),
		.wdata (t_wd_q),
		.raddr (tp_q[TAW-1:0]),
		.rdata (t_rd)
	);

	// Read address: upward shift walks down from the top
	assign rp_dn = rp_q - FCW'(1);
	assign s_ra  = (state_q == S_SHUP) ? rp_dn[FAW-1:0] : rp_q[FAW-1:0];

	// Ends and sums, 17 bits where the compare is unmasked
	assign l_end    = {1'b0, left_q.idx} + {1'b0, left_q.cap};
	assign r_need   = {1'b0, handle_q} + {1'b0, cap_q};
	assign lm_end   = {1'b0, left_q.idx} + {1'b0, newcap_q};
	assign bump_end = {1'b0, bump_q} + {1'b0, count_q};
	assign shr_idx  = s_rd.idx + count_q;
	assign shr_cap  = s_rd.cap - count_q;
	assign newcap   = left_q.cap + cap_q;
	assign rmcap    = right_q.cap + cap_q;
	assign lrcap    = newcap_q + right_q.cap;
	assign left_ok  = (pos_q != '0) && (l_end == {1'b0, handle_q});
	assign right_ok = has_right_q && ({1'b0, right_q.idx} == r_need);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			fcnt_q      <= '0;
			bump_q      <= '0;
			pend_s1     <= 1'b0;
			s_we_q      <= 1'b0;
			t_we_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			s_we_q  <= 1'b0;
			t_we_q  <= 1'b0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			unique case (state_q)
				// clearing pass over the table after reset
				S_CLR: begin
					t_we_q <= 1'b1;
					t_wa_q <= clr_q[TAW-1:0];
					t_wd_q <= '0;
					clr_q  <= clr_q + TCW'(1);
					if (clr_q == TCW'(ALLOC_TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						count_q  <= count;
						handle_q <= handle;
						tp_q     <= '0;
						rp_q     <= '0;
						if (mode == MODE_FREE) begin
							state_q <= S_FTAB;
						end else if (count == '0) begin
							done_q   <= 1'b1;
							sidx_q   <= '0;
							status_q <= ST_CAPACITY;
						end else begin
							state_q <= S_ATAB;
						end
					end
				end
				// find a free table entry
				S_ATAB: begin
					if (pend_s1 && !t_rd.vld) begin
						t_q     <= tpa_s1;
						state_q <= S_ASLOT;
					end else if (tp_q < TCW'(ALLOC_TABLE_DEPTH)) begin
						tp_q    <= tp_q + TCW'(1);
						pend_s1 <= 1'b1;
						tpa_s1  <= tp_q[TAW-1:0];
					end else begin
						done_q   <= 1'b1;
						sidx_q   <= '0;
						status_q <= ST_TABLE_FULL;
						state_q  <= S_IDLE;
					end
				end
				// first slot that fits
				S_ASLOT: begin
					if (pend_s1 && (count_q <= s_rd.cap)) begin
						t_we_q   <= 1'b1;
						t_wa_q   <= t_q;
						t_wd_q   <= '{vld: 1'b1, start: s_rd.idx, size: count_q};
						sidx_q   <= s_rd.idx;
						status_q <= ST_OK;
						if (count_q < s_rd.cap) begin
							s_we_q  <= 1'b1;
							s_wa_q  <= spa_s1[FAW-1:0];
							s_wd_q  <= '{idx: shr_idx, cap: shr_cap};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							rp_q    <= spa_s1 + FCW'(1);
							state_q <= S_SHDN;
						end
					end else if (rp_q < fcnt_q) begin
						rp_q    <= rp_q + FCW'(1);
						pend_s1 <= 1'b1;
						spa_s1  <= rp_q;
					end else begin
						state_q <= S_ABUMP;
					end
				end
				// carve from the bump pointer
				S_ABUMP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (bump_end < {1'b0, max_index}) begin
						t_we_q   <= 1'b1;
						t_wa_q   <= t_q;
						t_wd_q   <= '{vld: 1'b1, start: bump_q, size: count_q};
						bump_q   <= bump_end[IDX_W-1:0];
						sidx_q   <= bump_q;
						status_q <= ST_OK;
					end else begin
						sidx_q   <= '0;
						status_q <= ST_CAPACITY;
					end
				end
				// close the gap: entry r moves to r-1
				S_SHDN: begin
					if (pend_s1) begin
						s_we_q <= 1'b1;
						s_wa_q <= FAW'(spa_s1 - FCW'(1));
						s_wd_q <= s_rd;
					end
					if (rp_q < fcnt_q) begin
						rp_q    <= rp_q + FCW'(1);
						pend_s1 <= 1'b1;
						spa_s1  <= rp_q;
					end else if (!pend_s1) begin
						fcnt_q  <= fcnt_q - FCW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				// look the handle up
				S_FTAB: begin
					if (pend_s1 && t_rd.vld && (t_rd.start == handle_q)) begin
						t_q     <= tpa_s1;
						cap_q   <= t_rd.size;
						state_q <= S_FPOS;
					end else if (tp_q < TCW'(ALLOC_TABLE_DEPTH)) begin
						tp_q    <= tp_q + TCW'(1);
						pend_s1 <= 1'b1;
						tpa_s1  <= tp_q[TAW-1:0];
					end else begin
						done_q   <= 1'b1;
						sidx_q   <= '0;
						status_q <= ST_UNKNOWN;
						state_q  <= S_IDLE;
					end
				end
				// sorted position, keeping left and right neighbours
				S_FPOS: begin
					if (pend_s1 && (s_rd.idx >= handle_q)) begin
						pos_q       <= spa_s1;
						right_q     <= s_rd;
						has_right_q <= 1'b1;
						state_q     <= S_FDEC;
					end else begin
						if (pend_s1) begin
							left_q <= s_rd;
						end
						if (rp_q < fcnt_q) begin
							rp_q    <= rp_q + FCW'(1);
							pend_s1 <= 1'b1;
							spa_s1  <= rp_q;
						end else begin
							pos_q       <= fcnt_q;
							has_right_q <= 1'b0;
							state_q     <= S_FDEC;
						end
					end
				end
				// pick merge or insert, or report a full list
				S_FDEC: begin
					sidx_q   <= '0;
					status_q <= ST_OK;
					t_wa_q   <= t_q;
					t_wd_q   <= '0;
					priority if (left_ok) begin
						t_we_q   <= 1'b1;
						newcap_q <= newcap;
						state_q  <= S_FLM;
					end else if (right_ok) begin
						t_we_q  <= 1'b1;
						s_we_q  <= 1'b1;
						s_wa_q  <= pos_q[FAW-1:0];
						s_wd_q  <= '{idx: handle_q, cap: rmcap};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (fcnt_q >= FCW'(FREE_SLOT_DEPTH)) begin
						status_q <= ST_LIST_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						t_we_q  <= 1'b1;
						rp_q    <= fcnt_q;
						state_q <= S_SHUP;
					end
				end
				// left merge, maybe absorbing the right neighbour
				S_FLM: begin
					s_we_q <= 1'b1;
					s_wa_q <= FAW'(pos_q - FCW'(1));
					if (has_right_q && (lm_end == {1'b0, right_q.idx})) begin
						s_wd_q  <= '{idx: left_q.idx, cap: lrcap};
						rp_q    <= pos_q + FCW'(1);
						state_q <= S_SHDN;
					end else begin
						s_wd_q  <= '{idx: left_q.idx, cap: newcap_q};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				// open a gap: entry r moves to r+1, top down
				S_SHUP: begin
					if (pend_s1) begin
						s_we_q <= 1'b1;
						s_wa_q <= FAW'(spa_s1 + FCW'(1));
						s_wd_q <= s_rd;
					end
					if (rp_q > pos_q) begin
						rp_q    <= rp_dn;
						pend_s1 <= 1'b1;
						spa_s1  <= rp_dn;
					end else if (!pend_s1) begin
						state_q <= S_FINS;
					end
				end
				S_FINS: begin
					s_we_q  <= 1'b1;
					s_wa_q  <= pos_q[FAW-1:0];
					s_wd_q  <= '{idx: handle_q, cap: cap_q};
					fcnt_q  <= fcnt_q + FCW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign start_index = sidx_q;
	assign status      = status_q;

endmodule

/* rtl/first_fit_range_allocator.sv */
// First-fit range allocator. A request (mode, count, handle) is taken when
// start is high and busy is low; its one result appears on start_index and
// status for exactly one cycle with done high, and cannot be held off.
// Each request walks the allocation table and the sorted free list through
// stores with one write and one registered read port, one entry a cycle,
// and may shift free-list entries one a cycle; it ends sooner when an early
// table entry is free or the list is short. A zero-count allocation is
// answered from idle with status ST_CAPACITY. After reset the block clears
// every table entry with busy high. max_index is written on the cfg channel,
// always ready; writes only while idle are up to the user, not enforced.
module first_fit_range_allocator
	import ffra_pkg::*;
#(
	parameter int FREE_SLOT_DEPTH   = 32,
	parameter int ALLOC_TABLE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             mode,
	input  logic [IDX_W-1:0] count,
	input  logic [IDX_W-1:0] handle,
	output logic             done,
	output logic [IDX_W-1:0] start_index,
	output logic [ST_W-1:0]  status,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_data
);

	logic [IDX_W-1:0] max_index_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_index_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			max_index_q <= cfg_data;
		end
	end

	ffra_ctrl #(
		.FREE_SLOT_DEPTH   (FREE_SLOT_DEPTH),
		.ALLOC_TABLE_DEPTH (ALLOC_TABLE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.count       (count),
		.handle      (handle),
		.max_index   (max_index_q),
		.busy        (busy),
		.done        (done),
		.start_index (start_index),
		.status      (status)
	);

	`include "assert_macros.svh"

	`CHK_IMP(a_done_idle, done, !busy)
	`CHK_IMP(a_err_zero, done && (status != ST_OK), start_index == '0)
	`CHK_IMP(a_status_range, done, status <= ST_TABLE_FULL)

endmodule
